@@ design/assert_macros.svh @@
// Assertion macros shared by the top level and the sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ design/slid_pkg.sv @@
// Shared types and codes for the sorted list block.
package slid_pkg;

    localparam logic [1:0] KIND_INSERT     = 2'd0;
    localparam logic [1:0] KIND_POP_HEAD   = 2'd1;
    localparam logic [1:0] KIND_REMOVE_ALL = 2'd2;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_EVAL,
        ST_HEAD,
        ST_DONE
    } slid_state_t;

    typedef struct packed {
        logic [4:0]  entry_count;
        logic [15:0] head_value;
        logic        head_valid;
        logic        removed_any;
        logic [1:0]  status;
    } slid_result_t;

endpackage

@@ design/sorted_list_insert_delete.sv @@
// Top level of the bounded sorted list with insert and delete operations.
//
// This block keeps up to DEPTH signed values of DATA_WIDTH bits in ascending
// order, duplicates allowed, and runs one operation per input beat: a sorted
// insert, a removal of the smallest entry, or a removal of every entry equal
// to the given value; the unused fourth kind code does nothing. Each input
// beat yields exactly one result beat that reports the status, whether a
// remove-all found a match, the new head and the entry count. All work goes
// through one memory with a single write port and a registered read port,
// walked by a sequencer that compares one stored entry per step. The input
// is not ready while an operation runs; a finished result waits in an output
// register, so the next beat is taken while the previous result is still
// unclaimed. The store has no reset of its own: only the entry count is
// cleared, and only entries below the count are ever used. Out-of-range value
// bits above DATA_WIDTH are dropped and the value is taken as a signed number
// of DATA_WIDTH bits.
`include "assert_macros.svh"

module sorted_list_insert_delete #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input beats.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] value
    input  logic [1:0]  s_tuser,   // [1:0] kind
    // Result beats.
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] status, [2] removed_any, [3] head_valid, [19:4] head_value,
    // [24:20] entry_count, [31:25] zero
    output logic [31:0] m_tdata
);

    import slid_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic signed [31:0]           value_ext;
    logic signed [DATA_WIDTH-1:0] in_value;
    logic                         out_free;
    logic                         seq_done;
    slid_result_t                 seq_result;

    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    logic signed [DATA_WIDTH-1:0] mem_wdata;
    logic                         mem_re;
    logic [AW-1:0]                mem_raddr;
    logic signed [DATA_WIDTH-1:0] mem_rdata;

    logic                         out_valid_reg, out_valid_next;
    slid_result_t                 out_data_reg, out_data_next;

    // The value is sign-extended and then cut to the stored width.
    assign value_ext = 32'(signed'(s_tdata));
    assign in_value  = value_ext[DATA_WIDTH-1:0];

    // The output register frees up in the same cycle its beat is taken.
    assign out_free = !out_valid_reg || m_tready;

    slid_seq #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_kind   (s_tuser),
        .in_value  (in_value),
        .in_ready  (s_tready),
        .out_free  (out_free),
        .done      (seq_done),
        .result    (seq_result),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    slid_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_free)
        begin
            out_valid_next = seq_done;
            if (seq_done)
            begin
                out_data_next = seq_result;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_data_reg};

    `ASSERT_IMPL(a_done_not_ready, clk, rst_n, seq_done, !s_tready)
    `ASSERT_NEXT(a_done_loads, clk, rst_n, (seq_done && out_free), m_tvalid)
    `ASSERT_IMPL(a_head_matches, clk, rst_n, m_tvalid, (m_tdata[3] == (m_tdata[24:20] != 5'd0)) || (DEPTH > 31))

endmodule

@@ design/slid_mem.sv @@
// Entry store: one write port and one registered read port.
module slid_mem #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [$clog2(DEPTH)-1:0]      waddr,
    input  logic signed [DATA_WIDTH-1:0]  wdata,
    input  logic                          re,
    input  logic [$clog2(DEPTH)-1:0]      raddr,
    output logic signed [DATA_WIDTH-1:0]  rdata
);

    logic signed [DATA_WIDTH-1:0] mem [DEPTH];
    logic signed [DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/slid_seq.sv @@
// Sequencer that walks the store with a single shared compare unit.
`include "assert_macros.svh"

module slid_seq #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [1:0]                    in_kind,
    input  logic signed [DATA_WIDTH-1:0]  in_value,
    output logic                          in_ready,
    input  logic                          out_free,
    output logic                          done,
    output slid_pkg::slid_result_t        result,
    output logic                          mem_we,
    output logic [$clog2(DEPTH)-1:0]      mem_waddr,
    output logic signed [DATA_WIDTH-1:0]  mem_wdata,
    output logic                          mem_re,
    output logic [$clog2(DEPTH)-1:0]      mem_raddr,
    input  logic signed [DATA_WIDTH-1:0]  mem_rdata
);

    import slid_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE      = CNT_W'(1);

    slid_state_t                  state_reg, state_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [CNT_W-1:0]             ptr_reg, ptr_next;
    logic [CNT_W-1:0]             wr_reg, wr_next;
    logic [1:0]                   status_reg, status_next;
    logic                         removed_reg, removed_next;
    logic [1:0]                   kind_reg, kind_next;
    logic signed [DATA_WIDTH-1:0] val_reg, val_next;

    logic                         data_lt;
    logic                         data_eq;
    logic [CNT_W-1:0]             ptr_dec;
    logic signed [31:0]           head_ext;
    logic [31:0]                  count_ext;

    // The shared compare unit: stored entry against the operand.
    assign data_lt = mem_rdata < val_reg;
    assign data_eq = mem_rdata == val_reg;
    assign ptr_dec = ptr_reg - ONE;

    assign head_ext  = 32'(mem_rdata);
    assign count_ext = 32'(count_reg);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        wr_next      = wr_reg;
        status_next  = status_reg;
        removed_next = removed_reg;
        kind_next    = kind_reg;
        val_next     = val_reg;
        mem_we       = 1'b0;
        mem_waddr    = ptr_reg[AW-1:0];
        mem_wdata    = mem_rdata;
        mem_re       = 1'b0;
        mem_raddr    = ptr_reg[AW-1:0];
        in_ready     = 1'b0;
        done         = 1'b0;

        result.status      = status_reg;
        result.removed_any = removed_reg;
        result.head_valid  = count_reg != '0;
        result.head_value  = (count_reg != '0) ? head_ext[15:0] : 16'd0;
        result.entry_count = count_ext[4:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    kind_next    = in_kind;
                    val_next     = in_value;
                    status_next  = STATUS_DONE;
                    removed_next = 1'b0;
                    wr_next      = '0;
                    state_next   = ST_RD;
                    unique case (in_kind)
                        KIND_INSERT:
                        begin
                            ptr_next = count_reg;
                            if (count_reg == FULL_CNT)
                            begin
                                status_next = STATUS_FULL;
                                state_next  = ST_HEAD;
                            end
                        end
                        KIND_POP_HEAD:
                        begin
                            ptr_next = ONE;
                            if (count_reg == '0)
                            begin
                                status_next = STATUS_EMPTY;
                                state_next  = ST_HEAD;
                            end
                        end
                        KIND_REMOVE_ALL:
                        begin
                            ptr_next = '0;
                        end
                        default:
                        begin
                            state_next = ST_HEAD;
                        end
                    endcase
                end
            end
            ST_RD:
            begin
                if (kind_reg == KIND_INSERT)
                begin
                    if (ptr_reg == '0)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = '0;
                        mem_wdata  = val_reg;
                        count_next = count_reg + ONE;
                        state_next = ST_HEAD;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = ptr_dec[AW-1:0];
                        state_next = ST_EVAL;
                    end
                end
                else if (ptr_reg >= count_reg)
                begin
                    count_next = (kind_reg == KIND_POP_HEAD) ? count_reg - ONE : wr_reg;
                    state_next = ST_HEAD;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = ST_RD;
                if (kind_reg == KIND_INSERT)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ptr_reg[AW-1:0];
                    if (data_lt)
                    begin
                        mem_wdata  = val_reg;
                        count_next = count_reg + ONE;
                        state_next = ST_HEAD;
                    end
                    else
                    begin
                        ptr_next = ptr_dec;
                    end
                end
                else if (kind_reg == KIND_POP_HEAD)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ptr_dec[AW-1:0];
                    ptr_next  = ptr_reg + ONE;
                end
                else
                begin
                    ptr_next = ptr_reg + ONE;
                    if (data_eq)
                    begin
                        removed_next = 1'b1;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = wr_reg[AW-1:0];
                        wr_next   = wr_reg + ONE;
                    end
                end
            end
            ST_HEAD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = '0;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                done = 1'b1;
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            ptr_reg     <= '0;
            wr_reg      <= '0;
            status_reg  <= STATUS_DONE;
            removed_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ptr_reg     <= ptr_next;
            wr_reg      <= wr_next;
            status_reg  <= status_next;
            removed_reg <= removed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        val_reg  <= val_next;
    end

    `ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= FULL_CNT)
    `ASSERT_IMPL(a_ptr_bound, clk, rst_n, (state_reg == ST_RD || state_reg == ST_EVAL), ptr_reg <= count_reg)
    `ASSERT_IMPL(a_compact_bound, clk, rst_n, (state_reg == ST_EVAL && kind_reg == KIND_REMOVE_ALL), wr_reg <= ptr_reg)
    `ASSERT_NEXT(a_full_keeps, clk, rst_n, (in_valid && in_ready && in_kind == KIND_INSERT && count_reg == FULL_CNT), count_reg == FULL_CNT)

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for sorted_list_insert_delete, driven by directed and random beats.
module tb;
    import slid_pkg::*;

    // The fourth kind code is not an operation; the block must answer it as a no-op.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int LIST_DEPTH   = 16;
    // Cycles without any accepted beat before the run is declared hung, set well above one
    // full-store operation so that stalls on either side do not trip it.
    localparam int STALL_LIMIT  = 2000;
    // Cycles to keep watching after the last result, more than one full-store operation.
    localparam int DRAIN_CYCLES = 80;
    localparam int RANDOM_OPS   = 285;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] value;
    } list_op_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    sorted_list_insert_delete dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // Operations waiting to be driven, and results predicted for accepted beats.
    list_op_t     pending_ops[$];
    slid_result_t expected_results[$];

    // Predicted contents of the store: ascending in slots 0..list_len-1.
    logic signed [15:0] list_vals [LIST_DEPTH];
    int                 list_len = 0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int queued_total  = 0;
    int results_seen  = 0;
    int mismatch_count = 0;
    int idle_cycles   = 0;
    logic in_fire     = 1'b0;

    // Tallies of the interesting cases, for the closing summary.
    int full_rejects = 0;
    int empty_pops   = 0;
    int remove_hits  = 0;
    int unused_ops   = 0;
    int peak_len     = 0;

    // Applies one operation to the predicted store and returns the result beat it causes.
    function automatic slid_result_t apply_list_op(input logic [1:0] kind,
                                                   input logic signed [15:0] value);
        slid_result_t res;
        int pos;
        int wr;
        res = '0;
        case (kind)
            KIND_INSERT: begin
                if (list_len >= LIST_DEPTH) begin
                    res.status = STATUS_FULL;
                    full_rejects++;
                end else begin
                    // Goes in front of the first entry that is not smaller.
                    pos = 0;
                    while (pos < list_len && list_vals[pos] < value)
                        pos++;
                    for (int i = list_len; i > pos; i--)
                        list_vals[i] = list_vals[i - 1];
                    list_vals[pos] = value;
                    list_len++;
                end
            end
            KIND_POP_HEAD: begin
                if (list_len == 0) begin
                    res.status = STATUS_EMPTY;
                    empty_pops++;
                end else begin
                    for (int i = 1; i < list_len; i++)
                        list_vals[i - 1] = list_vals[i];
                    list_len--;
                end
            end
            KIND_REMOVE_ALL: begin
                wr = 0;
                for (int i = 0; i < list_len; i++) begin
                    if (list_vals[i] == value)
                        res.removed_any = 1'b1;
                    else begin
                        list_vals[wr] = list_vals[i];
                        wr++;
                    end
                end
                if (res.removed_any)
                    remove_hits++;
                list_len = wr;
            end
            default: begin
                unused_ops++;
            end
        endcase
        if (list_len > peak_len)
            peak_len = list_len;
        res.head_valid  = (list_len > 0);
        res.head_value  = (list_len > 0) ? list_vals[0] : '0;
        res.entry_count = 5'(list_len);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 20)
            $display("MISMATCH on result %0d, %s: got 0x%0h, expected 0x%0h",
                     results_seen, what, got, want);
    endtask

    task automatic queue_op(input logic [1:0] kind, input logic signed [15:0] value);
        list_op_t op;
        op.kind  = kind;
        op.value = value;
        pending_ops.push_back(op);
        queued_total++;
    endtask

    // Values lean on a small pool so that duplicates and remove-all matches are common,
    // with the extremes and fully random words mixed in.
    function automatic logic signed [15:0] pick_value();
        int roll;
        int small_val;
        roll = $urandom_range(99);
        if (roll < 45) begin
            small_val = $urandom_range(8);
            return 16'(small_val - 4);
        end
        if (roll < 60) begin
            case ($urandom_range(3))
                0: return 16'sh8000;
                1: return 16'sh7FFF;
                2: return 16'sh0000;
                default: return 16'shFFFF;
            endcase
        end
        return 16'($urandom);
    endfunction

    // Random operations in runs that mostly fill or mostly drain, so the store swings
    // between empty and full many times.
    task automatic queue_random_ops(input int count);
        int filling;
        int run_left;
        int roll;
        logic [1:0] kind;
        filling  = 1;
        run_left = 0;
        for (int n = 0; n < count; n++) begin
            if (run_left == 0) begin
                filling  = $urandom_range(1);
                run_left = $urandom_range(24, 4);
            end
            run_left--;
            roll = $urandom_range(99);
            if (roll < 3)
                kind = KIND_UNUSED;
            else if (filling ? (roll < 75) : (roll < 25))
                kind = KIND_INSERT;
            else
                kind = ($urandom_range(2) == 0) ? KIND_REMOVE_ALL : KIND_POP_HEAD;
            queue_op(kind, pick_value());
        end
    endtask

    task automatic wait_drained();
        while (results_seen < queued_total)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Driver: presents the next pending beat once the current one has been taken.
    always @(negedge clk) begin : drive_beats
        list_op_t nxt;
        if (rst_n) begin
            if (!s_tvalid || in_fire) begin
                if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_ops.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.value;
                    s_tuser  <= nxt.kind;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: predicts on every accepted input beat and checks every accepted result beat.
    always @(posedge clk) begin : watch_beats
        slid_result_t want;
        slid_result_t got;
        if (rst_n) begin
            in_fire <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_list_op(s_tuser, s_tdata));
            if (m_tvalid && m_tready) begin
                results_seen++;
                got = slid_result_t'(m_tdata[24:0]);
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing expected", m_tdata, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.removed_any !== want.removed_any)
                        report_mismatch("removed_any", got.removed_any, want.removed_any);
                    if (got.head_valid !== want.head_valid)
                        report_mismatch("head_valid", got.head_valid, want.head_valid);
                    if (got.head_value !== want.head_value)
                        report_mismatch("head_value", got.head_value, want.head_value);
                    if (got.entry_count !== want.entry_count)
                        report_mismatch("entry_count", got.entry_count, want.entry_count);
                    if (m_tdata[31:25] !== '0)
                        report_mismatch("padding bits", m_tdata[31:25], '0);
                end
            end
        end
    end

    // Watchdog: a long stretch with no beat accepted on either side means a hang.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("sorted_list_insert_delete test failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // First phase: sender idles a third of the time, receiver about half.
        send_idle_pct = 33;
        recv_idle_pct = 54;

        // Empty store: pop, remove-all and the unused code must all leave it empty.
        queue_op(KIND_POP_HEAD, 16'sh0000);
        queue_op(KIND_REMOVE_ALL, 16'sh0000);
        queue_op(KIND_UNUSED, 16'shFFFF);
        // Extremes, a duplicate, and a negative just below zero.
        queue_op(KIND_INSERT, 16'sh7FFF);
        queue_op(KIND_INSERT, 16'sh8000);
        queue_op(KIND_INSERT, 16'sh0000);
        queue_op(KIND_INSERT, 16'sh0000);
        queue_op(KIND_INSERT, 16'shFFFF);
        // Remove-all with two matches, then one with no match.
        queue_op(KIND_REMOVE_ALL, 16'sh0000);
        queue_op(KIND_REMOVE_ALL, 16'sh007B);
        queue_op(KIND_POP_HEAD, 16'sh5555);
        // Fill to the top, then one insert that must be rejected.
        for (int i = 0; i < LIST_DEPTH - 2; i++)
            queue_op(KIND_INSERT, pick_value());
        queue_op(KIND_INSERT, 16'sh0001);

        queue_random_ops(RANDOM_OPS);
        wait_drained();

        // Second phase: the idling rates swap sides.
        send_idle_pct = 54;
        recv_idle_pct = 33;
        queue_random_ops(RANDOM_OPS);
        wait_drained();

        // Last phase: both sides run flat out.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_ops(RANDOM_OPS);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("results never delivered", expected_results.size(), '0);

        $display("Ran %0d beats over three idling phases; peak fill %0d of %0d.",
                 results_seen, peak_len, LIST_DEPTH);
        $display("Saw %0d full rejects, %0d empty pops, %0d remove-all hits, %0d no-ops.",
                 full_rejects, empty_pops, remove_hits, unused_ops);
        if (mismatch_count == 0)
            $display("sorted_list_insert_delete test passed");
        else
            $display("sorted_list_insert_delete test failed");
        $finish;
    end

endmodule
